// File: rtl/i2cseq_pkg.sv
// Shared types and constants for the two-wire master transaction sequencer.
package i2cseq_pkg;

  // Input item: a begin request or a status event from the bus interface.
  typedef struct packed {
    logic        op;
    logic        is_read;
    logic [6:0]  dev_addr;
    logic [31:0] sub_addr;
    logic [2:0]  addr_bytes;
    logic [7:0]  byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  // Result item: the control/data register writes for one step.
  typedef struct packed {
    logic [7:0] cmd_value;
    logic       data_write;
    logic [7:0] data_value;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic [1:0] error_code;
    logic       last;
  } res_item_t;

  // Transaction state carried between items.
  typedef struct packed {
    logic [2:0]  phase;
    logic        read_mode;
    logic [6:0]  target_addr;
    logic [31:0] reg_addr;
    logic [2:0]  addr_left;
    logic [7:0]  bytes_left;
  } seq_state_t;

  localparam logic [2:0] MAX_ADDR_BYTES = 3'd4;

  // Item kinds
  localparam logic OP_BEGIN = 1'b0;

  // Phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START_W = 3'd1;
  localparam logic [2:0] PH_WRITE   = 3'd2;
  localparam logic [2:0] PH_START_R = 3'd3;
  localparam logic [2:0] PH_ADDR_R  = 3'd4;
  localparam logic [2:0] PH_RX      = 3'd5;

  // Control register bytes
  localparam logic [7:0] CMD_START = 8'hA4;
  localparam logic [7:0] CMD_GO    = 8'h84;
  localparam logic [7:0] CMD_ACK   = 8'hC4;
  localparam logic [7:0] CMD_STOP  = 8'h94;

  // Status codes (low three bits masked)
  localparam logic [7:0] STATUS_MASK    = 8'hF8;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUS  = 2'd1;
  localparam logic [1:0] ERR_NACK = 2'd2;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

endpackage

// File: rtl/i2cseq_step.sv
// Next-state and result logic for one sequencer step.
module i2cseq_step
  import i2cseq_pkg::*;
(
  input  in_item_t   item,
  input  seq_state_t st,
  output seq_state_t st_nxt,
  output logic [1:0] res_cnt,
  output res_item_t  res0,
  output res_item_t  res1
);

  logic [7:0] code;
  logic [2:0] n_addr;
  logic [2:0] addr_dec;
  logic [7:0] bl_dec;
  logic       bl_nz;
  logic [7:0] rx_pass;
  logic [7:0] addr_byte;

  assign code     = item.status_code & STATUS_MASK;
  assign n_addr   = (item.addr_bytes > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES : item.addr_bytes;
  assign addr_dec = 3'(st.addr_left - 3'd1);
  assign addr_byte = st.reg_addr[{addr_dec[1:0], 3'b000} +: 8];
  assign bl_nz    = (st.bytes_left != 8'd0);
  assign bl_dec   = bl_nz ? 8'(st.bytes_left - 8'd1) : st.bytes_left;
  assign rx_pass  = bl_nz ? item.rx_byte : 8'd0;

  always_comb begin
    st_nxt  = st;
    res_cnt = 2'd0;
    res0    = '0;
    res1    = '0;
    if (item.op == OP_BEGIN) begin
      st_nxt.read_mode   = item.is_read;
      st_nxt.target_addr = item.dev_addr;
      st_nxt.reg_addr    = item.sub_addr;
      st_nxt.addr_left   = n_addr;
      st_nxt.bytes_left  = item.byte_count;
      st_nxt.phase       = (item.is_read && n_addr == 3'd0) ? PH_START_R : PH_START_W;
      res_cnt            = 2'd1;
      res0.cmd_value     = CMD_START;
      res0.last          = 1'b1;
    end else begin
      res_cnt   = 2'd1;
      res0.last = 1'b1;
      // bus error unless an arm below says otherwise
      res0.cmd_value  = CMD_GO;
      res0.done_res   = 1'b1;
      res0.error_code = ERR_BUS;
      st_nxt.phase    = PH_IDLE;
      unique case (st.phase)
        PH_START_W: begin
          if (code == ST_START) begin
            st_nxt.phase    = PH_WRITE;
            res0.done_res   = 1'b0;
            res0.error_code = ERR_NONE;
            res0.data_write = 1'b1;
            res0.data_value = {st.target_addr, 1'b0};
          end
        end
        PH_WRITE: begin
          if (code == ST_SLA_W_ACK || code == ST_DATA_W_ACK) begin
            st_nxt.phase    = PH_WRITE;
            res0.done_res   = 1'b0;
            res0.error_code = ERR_NONE;
            if (st.addr_left != 3'd0) begin
              st_nxt.addr_left = addr_dec;
              res0.data_write  = 1'b1;
              res0.data_value  = addr_byte;
            end else if (st.read_mode) begin
              // address sent: stop, then repeated start for the read
              st_nxt.phase   = PH_START_R;
              res_cnt        = 2'd2;
              res0.cmd_value = CMD_STOP;
              res0.last      = 1'b0;
              res1.cmd_value = CMD_START;
              res1.last      = 1'b1;
            end else if (bl_nz) begin
              st_nxt.bytes_left = bl_dec;
              res0.data_write   = 1'b1;
              res0.data_value   = item.tx_byte;
              res0.tx_taken     = 1'b1;
            end else begin
              st_nxt.phase   = PH_IDLE;
              res0.cmd_value = CMD_STOP;
              res0.done_res  = 1'b1;
            end
          end else if (code == ST_SLA_W_NACK || code == ST_DATA_W_NACK) begin
            res0.cmd_value  = CMD_STOP;
            res0.error_code = ERR_NACK;
          end
        end
        PH_START_R: begin
          if (code == ST_START || code == ST_RESTART) begin
            st_nxt.phase    = PH_ADDR_R;
            res0.done_res   = 1'b0;
            res0.error_code = ERR_NONE;
            res0.data_write = 1'b1;
            res0.data_value = {st.target_addr, 1'b1};
          end
        end
        PH_ADDR_R: begin
          if (code == ST_SLA_R_ACK) begin
            st_nxt.phase    = PH_RX;
            res0.done_res   = 1'b0;
            res0.error_code = ERR_NONE;
            res0.cmd_value  = (st.bytes_left <= 8'd1) ? CMD_GO : CMD_ACK;
          end else if (code == ST_SLA_R_NACK) begin
            res0.cmd_value  = CMD_STOP;
            res0.error_code = ERR_NACK;
          end
        end
        PH_RX: begin
          if (code == ST_DATA_R_ACK) begin
            st_nxt.phase      = PH_RX;
            st_nxt.bytes_left = bl_dec;
            res0.done_res     = 1'b0;
            res0.error_code   = ERR_NONE;
            res0.cmd_value    = (bl_dec <= 8'd1) ? CMD_GO : CMD_ACK;
            res0.rx_valid     = bl_nz;
            res0.rx_data      = rx_pass;
          end else if (code == ST_DATA_R_NACK) begin
            st_nxt.bytes_left = bl_dec;
            res0.error_code   = ERR_NONE;
            res0.cmd_value    = CMD_STOP;
            res0.rx_valid     = bl_nz;
            res0.rx_data      = rx_pass;
          end
        end
        default: begin
          // idle: events are dropped
          res_cnt = 2'd0;
          res0    = '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/i2cseq_outq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
module i2cseq_outq
  import i2cseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_item_t  push0,
  input  res_item_t  push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_item_t  out_data
);

  res_item_t             mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OQ_PTR_W-1:0]   wr_ptr_p1;
  logic                  pop;

  assign pop        = out_valid && out_ready;
  assign wr_ptr_p1  = OQ_PTR_W'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = OQ_PTR_W'(wr_ptr_r + push_n);
  assign rd_ptr_nxt = pop ? OQ_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign cnt_nxt    = OQ_CNT_W'(cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop));

  // room for a worst-case pair
  assign room      = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// File: rtl/i2c_master_transaction_sequencer_top.sv
// Top level of the two-wire master transaction sequencer.
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+-----------------------------------
//  in       | in_valid in_ready in_data     | begin request or status event
//  out      | out_valid out_ready out_data  | control/data register write, rx
//
//  Each transfer on in is worked as one step: the step logic reads the
//  sequencer state and the item and writes zero, one or two results into a
//  four-entry result queue, updating the state in the same edge.
//  in_ready is high while the queue has room for two results, so with out_ready
//  held high one transfer is taken every cycle until STOP/START pairs fill the
//  queue. Reset (rst_n low, synchronous) empties the queue and sets the
//  sequencer idle. A stall on out backs up in once three results wait.
module i2c_master_transaction_sequencer_top
  import i2cseq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  seq_state_t state_r, state_nxt;
  seq_state_t step_nxt;
  logic [1:0] res_cnt;
  logic [1:0] push_n;
  res_item_t  res0, res1;
  logic       in_xfer;
  logic       room;

  assign in_ready = room;
  assign in_xfer  = in_valid && in_ready;

  i2cseq_step u_step (
    .item    (in_data),
    .st      (state_r),
    .st_nxt  (step_nxt),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // state only moves on an accepted transfer
  assign state_nxt = in_xfer ? step_nxt : state_r;
  assign push_n    = in_xfer ? res_cnt : 2'd0;

  // all-zero state is idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  i2cseq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/i2cseq_chk.sv
// Port-level checks for the sequencer, bound to the top level.
module i2cseq_chk
  import i2cseq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input res_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset leaves the queue empty and ready for a transfer
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // the first half of a pair is STOP, followed at once by START
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.cmd_value == CMD_START && out_data.last)
    else $error("broken STOP/START pair");

  // a finished transaction is always the last result of its step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.last)
    else $error("done without last");

endmodule

bind i2c_master_transaction_sequencer_top i2cseq_chk u_chk (.*);
